>>> rtl/p8au_pkg.sv
// ----------------------------------------------------------------------------
// p8au_pkg - shared types, constants and decode functions
// Posit8 (es=0) transaction formats, operation codes and the fixed-point
// decode used by the arithmetic pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package p8au_pkg;

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_MUL   = 4'd2,
    OP_DIV   = 4'd3,
    OP_RECIP = 4'd4,
    OP_NEG   = 4'd5,
    OP_LT    = 4'd6,
    OP_LE    = 4'd7,
    OP_GT    = 4'd8,
    OP_GE    = 4'd9,
    OP_EQ    = 4'd10,
    OP_F2P   = 4'd11,
    OP_P2F   = 4'd12
  } op_t;

  localparam logic [7:0]  NAR_CODE  = 8'h80;
  localparam logic [7:0]  POS_MAX   = 8'h7F;
  localparam logic [31:0] FLOAT_NAR = 32'h7FC0_0000;

  localparam int UNIT_W    = 14;  // signed value in units of 2^-6
  localparam int UMAG_W    = 13;  // magnitude of a decoded posit
  localparam int MAG_W     = 36;  // rounder input magnitude
  localparam int EXP_W     = 10;  // rounder input exponent
  localparam int DIV_FRAC  = 23;  // quotient fraction bits
  localparam int DIV_STEPS = 4;   // quotient bits per divider stage
  localparam int DIV_STAGES = MAG_W / DIV_STEPS;

  typedef struct packed {
    logic [3:0]  mode;
    logic [7:0]  operand_a;
    logic [7:0]  operand_b;
    logic [31:0] float_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  posit_out;
    logic [31:0] float_out;
    logic        cond;
  } out_item_t;

  // value to be rounded: (-1)^neg * mag * 2^expo, plus a nonzero tail if sticky
  typedef struct packed {
    logic                    neg;
    logic [MAG_W-1:0]        mag;
    logic signed [EXP_W-1:0] expo;
    logic                    sticky;
  } round_req_t;

  // result parts settled before rounding
  typedef struct packed {
    logic        use_round;
    logic [7:0]  posit_fix;
    logic [31:0] float_out;
    logic        cond;
  } side_t;

  function automatic logic signed [UNIT_W-1:0] p8_to_units(input logic [7:0] code);
    logic [7:0]  m;
    logic        b6;
    logic        run;
    int          n;
    int          rem;
    int          sc;
    int          e;
    int          frac;
    int          mag;
    m   = code[7] ? 8'(-code) : code;
    b6  = m[6];
    n   = 0;
    run = 1'b1;
    for (int i = 0; i < 7; i++) begin
      if (run && (m[6-i] == b6)) begin
        n = n + 1;
      end else begin
        run = 1'b0;
      end
    end
    rem  = (n < 6) ? 6 - n : 0;
    frac = int'(m) & ((1 << rem) - 1);
    sc   = b6 ? n - 1 : -n;
    e    = sc + 6 - rem;
    mag  = ((1 << rem) + frac) << e;
    if (code == 8'h00 || code == NAR_CODE) begin
      return '0;
    end
    return code[7] ? UNIT_W'(-mag) : UNIT_W'(mag);
  endfunction

  function automatic logic [31:0] p8_to_float(input logic [7:0] code);
    logic signed [UNIT_W-1:0] v;
    logic [UMAG_W-1:0]        mag;
    logic [31:0]              frac;
    int                       msb;
    v   = p8_to_units(code);
    mag = v[UNIT_W-1] ? UMAG_W'(-v) : UMAG_W'(v);
    msb = 0;
    for (int i = 0; i < UMAG_W; i++) begin
      if (mag[i]) begin
        msb = i;
      end
    end
    frac = (32'(mag) & ~(32'd1 << msb)) << (23 - msb);
    if (code == NAR_CODE) begin
      return FLOAT_NAR;
    end
    if (v == '0) begin
      return 32'd0;
    end
    return {v[UNIT_W-1], 8'(msb + 121), frac[22:0]};
  endfunction

endpackage

`default_nettype wire

>>> rtl/p8au_encode.sv
// ----------------------------------------------------------------------------
// p8au_encode - three-stage posit8 rounder
// Normalises a magnitude/exponent pair, builds the regime and fraction and
// rounds to nearest even, with saturation and minpos handling.
// ----------------------------------------------------------------------------
`default_nettype none

module p8au_encode (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     en,
  input  wire                     in_vld,
  input  p8au_pkg::round_req_t    req,
  input  p8au_pkg::side_t         side,
  output logic                    out_vld,
  output p8au_pkg::out_item_t     out_item
);
  import p8au_pkg::*;

  typedef struct packed {
    logic                    neg;
    logic                    zero;
    logic [5:0]              lz;
    logic [MAG_W-1:0]        mag;
    logic signed [EXP_W-1:0] expo;
    logic                    sticky;
    side_t                   side;
  } e1_t;

  typedef struct packed {
    logic                    neg;
    logic                    zero;
    logic signed [EXP_W-1:0] sc;
    logic [23:0]             frac;
    logic                    sticky;
    side_t                   side;
  } e2_t;

  e1_t       e1_r, e1_nxt;
  e2_t       e2_r, e2_nxt;
  out_item_t out_r, out_nxt;
  logic      v1_r, v2_r, v3_r;

  // leading-zero count
  always_comb begin
    e1_nxt.neg    = req.neg;
    e1_nxt.zero   = (req.mag == '0);
    e1_nxt.mag    = req.mag;
    e1_nxt.expo   = req.expo;
    e1_nxt.sticky = req.sticky;
    e1_nxt.side   = side;
    e1_nxt.lz     = 6'd0;
    for (int i = 0; i < MAG_W; i++) begin
      if (req.mag[i]) begin
        e1_nxt.lz = 6'(MAG_W - 1 - i);
      end
    end
  end

  // normalise, scale and fraction window
  logic [MAG_W-1:0] norm;
  always_comb begin
    norm          = e1_r.mag << e1_r.lz;
    e2_nxt.neg    = e1_r.neg;
    e2_nxt.zero   = e1_r.zero;
    e2_nxt.sc     = e1_r.expo + EXP_W'(MAG_W - 1) - EXP_W'(e1_r.lz);
    e2_nxt.frac   = norm[MAG_W-2 -: 24];
    e2_nxt.sticky = e1_r.sticky | (|norm[MAG_W-26:0]);
    e2_nxt.side   = e1_r.side;
  end

  // regime, fraction, round to nearest even
  int          scv;
  int          q;
  logic [23:0] regime;
  logic [31:0] wide;
  logic [23:0] win;
  logic [7:0]  code;
  logic        st;
  always_comb begin
    scv    = int'(e2_r.sc);
    q      = 0;
    regime = '0;
    wide   = '0;
    win    = '0;
    st     = 1'b0;
    if (scv > 6) begin
      code = POS_MAX;
    end else if (scv < -7) begin
      code = ((|e2_r.frac) || e2_r.sticky) ? 8'd1 : 8'd0;
    end else begin
      if (scv >= 0) begin
        q      = 20 - scv;
        regime = 24'((32'd1 << (scv + 1)) - 32'd1) << (22 - scv);
      end else begin
        q      = 21 + scv;
        regime = 24'd1 << (22 + scv);
      end
      wide = {e2_r.frac, 8'h00} >> (23 - q);
      win  = regime | wide[31:8];
      code = win[23:16];
      st   = (|win[14:0]) | (|wide[7:0]) | e2_r.sticky;
      if (win[15] && (st || code[0])) begin
        code = code + 8'd1;
      end
      if (code[7]) begin
        code = POS_MAX;
      end
    end
    if (e2_r.zero) begin
      code = 8'd0;
    end else if (e2_r.neg) begin
      code = 8'(-code);
    end
    out_nxt.posit_out = e2_r.side.use_round ? code : e2_r.side.posit_fix;
    out_nxt.float_out = e2_r.side.float_out;
    out_nxt.cond      = e2_r.side.cond;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_r  <= e1_nxt;
      e2_r  <= e2_nxt;
      out_r <= out_nxt;
    end
  end

  assign out_vld  = v3_r;
  assign out_item = out_r;

endmodule

`default_nettype wire

>>> rtl/posit8_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// posit8_arithmetic_unit - pipelined posit8 (es=0) arithmetic unit
// Add, subtract, multiply, divide, reciprocal, negate, compare and
// float32 conversion, one transaction per cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one in_item_t transaction: mode, two posit8 codes
//   and a float32 word. out_valid/out_ready return one out_item_t per
//   transaction, in order.
//   The stages are decode, operate, nine divider stages (four quotient bits
//   each) and three rounding stages, the last being the output register.
//   Every mode takes the same path, so order is kept. Throughput is one
//   transaction per cycle unless stalled; the divider is fully unrolled
//   over its stages, so a divide costs no more issue slots than an add.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds and in_ready drops in the same cycle; nothing is lost or repeated.
//   Reset (rst_n low, synchronous) clears every stage valid bit; payload
//   registers are left as they are.
// ----------------------------------------------------------------------------
`default_nettype none

module posit8_arithmetic_unit (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  p8au_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  wire                   out_ready,
  output p8au_pkg::out_item_t   out_data
);
  import p8au_pkg::*;

  // divider stage payload
  typedef struct packed {
    logic              isdiv;
    logic [UMAG_W-1:0] den;
    logic [UMAG_W-1:0] rem;
    round_req_t        req;
    side_t             side;
  } dstage_t;

  // decode stage payload
  typedef struct packed {
    logic [3:0]               mode;
    logic signed [UNIT_W-1:0] va;
    logic signed [UNIT_W-1:0] vb;
    logic [UMAG_W-1:0]        ma;
    logic [UMAG_W-1:0]        mb;
    logic                     anar;
    logic                     bnar;
    logic                     fnar;
    logic                     fneg;
    logic [23:0]              fmag;
    logic signed [EXP_W-1:0]  fexp;
    side_t                    side;
  } dec_t;

  logic stall;
  logic en;

  // hold everything while a finished result waits on the receiver
  assign stall    = out_valid && !out_ready;
  assign en       = !stall;
  assign in_ready = en;

  // ---------------------------------------------------------------- decode
  dec_t dec_r, dec_nxt;
  logic dec_v_r;

  logic signed [7:0] sa, sb;
  logic [7:0]        fex;
  logic              nar_any;

  always_comb begin
    sa      = signed'(in_data.operand_a);
    sb      = signed'(in_data.operand_b);
    fex     = in_data.float_in[30:23];
    nar_any = (in_data.operand_a == NAR_CODE) || (in_data.operand_b == NAR_CODE);

    dec_nxt.mode = in_data.mode;
    dec_nxt.va   = p8_to_units(in_data.operand_a);
    dec_nxt.vb   = p8_to_units(in_data.operand_b);
    dec_nxt.ma   = dec_nxt.va[UNIT_W-1] ? UMAG_W'(-dec_nxt.va) : UMAG_W'(dec_nxt.va);
    dec_nxt.mb   = dec_nxt.vb[UNIT_W-1] ? UMAG_W'(-dec_nxt.vb) : UMAG_W'(dec_nxt.vb);
    dec_nxt.anar = (in_data.operand_a == NAR_CODE);
    dec_nxt.bnar = (in_data.operand_b == NAR_CODE);

    // float32: subnormals keep their true value with the minimum exponent
    dec_nxt.fnar = (fex == 8'hFF);
    dec_nxt.fneg = in_data.float_in[31];
    dec_nxt.fmag = {(fex != 8'h00), in_data.float_in[22:0]};
    dec_nxt.fexp = (fex == 8'h00) ? -EXP_W'(149)
                                  : signed'(EXP_W'(fex)) - EXP_W'(150);

    dec_nxt.side = '0;
    case (in_data.mode)
      OP_NEG: dec_nxt.side.posit_fix = 8'(-in_data.operand_a);
      OP_LT:  dec_nxt.side.cond = !nar_any && (sa <  sb);
      OP_LE:  dec_nxt.side.cond = !nar_any && (sa <= sb);
      OP_GT:  dec_nxt.side.cond = !nar_any && (sa >  sb);
      OP_GE:  dec_nxt.side.cond = !nar_any && (sa >= sb);
      OP_EQ:  dec_nxt.side.cond = !nar_any && (sa == sb);
      OP_P2F: dec_nxt.side.float_out = p8_to_float(in_data.operand_a);
      default: ;
    endcase
  end

  // --------------------------------------------------------------- operate
  dstage_t                  ds_r [0:DIV_STAGES];
  logic [DIV_STAGES:0]      dv_r;
  dstage_t                  op_nxt;
  logic signed [UNIT_W:0]   sum;
  logic [2*UMAG_W-1:0]      prod;

  always_comb begin
    sum  = (dec_r.mode == OP_SUB)
           ? (UNIT_W+1)'(dec_r.va) - (UNIT_W+1)'(dec_r.vb)
           : (UNIT_W+1)'(dec_r.va) + (UNIT_W+1)'(dec_r.vb);
    prod = (2*UMAG_W)'(dec_r.ma) * (2*UMAG_W)'(dec_r.mb);

    op_nxt      = '0;
    op_nxt.side = dec_r.side;
    case (dec_r.mode)
      OP_ADD, OP_SUB: begin
        op_nxt.side.use_round = 1'b1;
        op_nxt.req.neg        = sum[UNIT_W];
        op_nxt.req.mag        = MAG_W'(sum[UNIT_W] ? -sum : sum);
        op_nxt.req.expo       = -EXP_W'(6);
      end
      OP_MUL: begin
        op_nxt.side.use_round = 1'b1;
        op_nxt.req.neg        = dec_r.va[UNIT_W-1] ^ dec_r.vb[UNIT_W-1];
        op_nxt.req.mag        = MAG_W'(prod);
        op_nxt.req.expo       = -EXP_W'(12);
      end
      OP_DIV: begin
        op_nxt.side.use_round = 1'b1;
        op_nxt.isdiv          = 1'b1;
        op_nxt.den            = dec_r.mb;
        op_nxt.req.neg        = dec_r.va[UNIT_W-1] ^ dec_r.vb[UNIT_W-1];
        op_nxt.req.mag        = MAG_W'(dec_r.ma) << DIV_FRAC;
        op_nxt.req.expo       = -EXP_W'(DIV_FRAC);
      end
      OP_RECIP: begin
        op_nxt.side.use_round = 1'b1;
        op_nxt.isdiv          = 1'b1;
        op_nxt.den            = dec_r.ma;
        op_nxt.req.neg        = dec_r.va[UNIT_W-1];
        op_nxt.req.mag        = MAG_W'(64) << DIV_FRAC;
        op_nxt.req.expo       = -EXP_W'(DIV_FRAC);
      end
      OP_F2P: begin
        op_nxt.side.use_round = 1'b1;
        op_nxt.req.neg        = dec_r.fneg;
        op_nxt.req.mag        = MAG_W'(dec_r.fmag);
        op_nxt.req.expo       = dec_r.fexp;
      end
      default: ;
    endcase

    // drop to NaR on NaR operands, division by zero and float specials
    if (((dec_r.mode == OP_ADD || dec_r.mode == OP_SUB || dec_r.mode == OP_MUL)
          && (dec_r.anar || dec_r.bnar)) ||
        ((dec_r.mode == OP_DIV) && (dec_r.anar || dec_r.bnar || dec_r.vb == '0)) ||
        ((dec_r.mode == OP_RECIP) && (dec_r.anar || dec_r.va == '0)) ||
        ((dec_r.mode == OP_F2P) && dec_r.fnar)) begin
      op_nxt.side.use_round = 1'b0;
      op_nxt.side.posit_fix = NAR_CODE;
      op_nxt.isdiv          = 1'b0;
    end
  end

  // --------------------------------------------------------------- divider
  // restoring division, quotient shifted into mag as the dividend leaves it
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    dstage_t         nxt;
    logic [UMAG_W:0] trial;
    logic            qbit;

    always_comb begin
      nxt   = ds_r[k];
      trial = '0;
      qbit  = 1'b0;
      for (int j = 0; j < DIV_STEPS; j++) begin
        if (nxt.isdiv) begin
          trial = {nxt.rem, nxt.req.mag[MAG_W-1]};
          qbit  = (trial >= {1'b0, nxt.den});
          if (qbit) begin
            trial = trial - {1'b0, nxt.den};
          end
          nxt.rem     = trial[UMAG_W-1:0];
          nxt.req.mag = {nxt.req.mag[MAG_W-2:0], qbit};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ds_r[k+1] <= nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_v_r <= 1'b0;
      dv_r    <= '0;
    end else if (en) begin
      dec_v_r <= in_valid;
      dv_r    <= {dv_r[DIV_STAGES-1:0], dec_v_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dec_r   <= dec_nxt;
      ds_r[0] <= op_nxt;
    end
  end

  // ------------------------------------------------------------------ round
  round_req_t enc_req;
  always_comb begin
    enc_req        = ds_r[DIV_STAGES].req;
    enc_req.sticky = ds_r[DIV_STAGES].req.sticky |
                     (ds_r[DIV_STAGES].isdiv && (ds_r[DIV_STAGES].rem != '0));
  end

  p8au_encode u_encode (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (dv_r[DIV_STAGES]),
    .req      (enc_req),
    .side     (ds_r[DIV_STAGES].side),
    .out_vld  (out_valid),
    .out_item (out_data)
  );

  // ------------------------------------------------------------- assertions
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> $stable(dv_r) && $stable(dec_v_r))
    else $error("pipeline valid bits moved during a stall");

  a_cond_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.cond) |-> (out_data.posit_out == 8'h00 &&
                                      out_data.float_out == 32'd0))
    else $error("comparison result carries other fields");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && (dv_r == '0))
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
